[src/ghq_pkg.sv]
`default_nettype none
package ghq_pkg;

  // Grid geometry
  localparam int GRID_SIDE  = 129;
  localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
  localparam int ADDR_W     = $clog2(GRID_CELLS);
  localparam int CELL_W     = $clog2(GRID_SIDE);

  // Fixed-point formats
  localparam int Q_W     = 32;               // Q16.16 word
  localparam int FRAC_W  = 16;
  localparam int ONE_Q16 = 65536;
  localparam int IDX_W   = 15;               // vertex index field
  localparam int TX_W    = 34;               // local coordinate / corner difference
  localparam int WT_W    = 17;               // unsigned multiplier operand
  localparam int MUL_W   = TX_W + WT_W + 1;  // signed product
  localparam int GX_W    = MUL_W;            // grid coordinate, Q.16
  localparam int CX_W    = GX_W - FRAC_W;    // integer cell, signed
  localparam int ACC_W   = MUL_W;            // interpolation sum, Q.32
  localparam int H_W     = ACC_W - FRAC_W + 1;

  // Stream and configuration port widths
  localparam int IN_FIELDS_W = IDX_W + 3 * Q_W;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int CFG_IDX_W   = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WORLD_X     = 3'd0,
    REG_WORLD_Z     = 3'd1,
    REG_WORLD_Y     = 3'd2,
    REG_ORIGIN_X    = 3'd3,
    REG_ORIGIN_Z    = 3'd4,
    REG_INV_SPACING = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } item_cmd_e;

  typedef enum logic [2:0] {
    MUL_XH,
    MUL_XL,
    MUL_ZH,
    MUL_ZL,
    MUL_D1,
    MUL_D2
  } mul_sel_e;

  typedef enum logic [1:0] {
    CORNER_LB,
    CORNER_RB,
    CORNER_LT,
    CORNER_RT
  } corner_e;

  typedef enum logic [1:0] {
    RES_HOLD,
    RES_WRITE,
    RES_OOR,
    RES_INTERP
  } res_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GXH,
    ST_GXL,
    ST_GZH,
    ST_GZL,
    ST_GZD,
    ST_CHECK,
    ST_READ,
    ST_RDW,
    ST_DIFF,
    ST_M1,
    ST_M2,
    ST_ACC,
    ST_FIN,
    ST_PUSH
  } state_e;

  typedef struct packed {
    logic     load_in;
    logic     wr_mem;
    mul_sel_e mul_sel;
    logic     hold_en;
    logic     gx_en;
    logic     gz_en;
    logic     chk_en;
    logic     rd_en;
    corner_e  corner;
    logic     diff_en;
    logic     acc_init;
    logic     acc_add;
    res_sel_e res_sel;
    logic     push;
  } ghq_cmd_t;

  typedef struct packed {
    logic in_range;
    logic out_free;
  } ghq_stat_t;

endpackage
`default_nettype wire

[src/ghq_ctrl.sv]
`default_nettype none
module ghq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              in_cmd,
  output logic                   in_ready,
  input  wire ghq_pkg::ghq_stat_t stat,
  output ghq_pkg::ghq_cmd_t      cmd
);
  import ghq_pkg::*;

  state_e  state, state_next;
  corner_e rd_cnt, rd_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      rd_cnt <= CORNER_LB;
    end else begin
      state  <= state_next;
      rd_cnt <= rd_cnt_next;
    end
  end

  always_comb begin
    state_next  = state;
    rd_cnt_next = rd_cnt;
    cmd         = '0;
    cmd.mul_sel = MUL_XH;
    cmd.corner  = rd_cnt;
    cmd.res_sel = RES_HOLD;
    in_ready    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (item_cmd_e'(in_cmd) == CMD_QUERY) begin
            cmd.load_in = 1'b1;
            state_next  = ST_GXH;
          end else begin
            cmd.wr_mem  = 1'b1;
            cmd.res_sel = RES_WRITE;
            state_next  = ST_PUSH;
          end
        end
      end
      ST_GXH: begin
        cmd.mul_sel = MUL_XH;
        state_next  = ST_GXL;
      end
      ST_GXL: begin
        cmd.mul_sel = MUL_XL;
        cmd.hold_en = 1'b1;
        state_next  = ST_GZH;
      end
      ST_GZH: begin
        cmd.mul_sel = MUL_ZH;
        cmd.gx_en   = 1'b1;
        state_next  = ST_GZL;
      end
      ST_GZL: begin
        cmd.mul_sel = MUL_ZL;
        cmd.hold_en = 1'b1;
        state_next  = ST_GZD;
      end
      ST_GZD: begin
        cmd.gz_en  = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.chk_en  = 1'b1;
        rd_cnt_next = CORNER_LB;
        if (stat.in_range) begin
          state_next = ST_READ;
        end else begin
          cmd.res_sel = RES_OOR;
          state_next  = ST_PUSH;
        end
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        if (rd_cnt == CORNER_RT) begin
          state_next = ST_RDW;
        end else begin
          rd_cnt_next = corner_e'(rd_cnt + 2'd1);
        end
      end
      ST_RDW: begin
        state_next = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.diff_en = 1'b1;
        state_next  = ST_M1;
      end
      ST_M1: begin
        cmd.mul_sel = MUL_D1;
        state_next  = ST_M2;
      end
      ST_M2: begin
        cmd.mul_sel  = MUL_D2;
        cmd.acc_init = 1'b1;
        state_next   = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc_add = 1'b1;
        state_next  = ST_FIN;
      end
      ST_FIN: begin
        cmd.res_sel = RES_INTERP;
        state_next  = ST_PUSH;
      end
      ST_PUSH: begin
        if (stat.out_free) begin
          cmd.push   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[src/ghq_dp.sv]
`default_nettype none
module ghq_dp (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire ghq_pkg::ghq_cmd_t                 cmd,
  output ghq_pkg::ghq_stat_t                     stat,
  input  wire logic                              cfg_valid,
  input  wire logic [ghq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ghq_pkg::Q_W-1:0]           cfg_data,
  output logic                                   cfg_ready,
  input  wire logic [ghq_pkg::IDX_W-1:0]         vertex_index,
  input  wire logic signed [ghq_pkg::Q_W-1:0]    write_height,
  input  wire logic signed [ghq_pkg::Q_W-1:0]    query_x,
  input  wire logic signed [ghq_pkg::Q_W-1:0]    query_z,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [ghq_pkg::Q_W-1:0]                out_height,
  output logic                                   out_oor
);
  import ghq_pkg::*;

  // Configuration registers
  logic signed [Q_W-1:0] world_x, world_z, world_y, origin_x, origin_z;
  logic        [Q_W-1:0] inv_spacing;

  // Coordinate and interpolation datapath
  logic signed [TX_W-1:0]  tx, tz;
  logic signed [TX_W-1:0]  mul_a;
  logic        [WT_W-1:0]  mul_b;
  logic signed [MUL_W-1:0] mul_p, mul_q, hold_q;
  logic signed [GX_W-1:0]  gx, gz, g_sum;
  logic signed [CX_W-1:0]  cx, cz;
  logic        [ADDR_W-1:0] base, base_next, rd_addr, mem_addr;
  logic        [FRAC_W-1:0] fx, fz;
  logic        lower;
  logic        mem_we;
  logic signed [Q_W-1:0]   mem[GRID_CELLS];
  logic signed [Q_W-1:0]   mem_q;
  logic        cap_q;
  corner_e     cap_idx;
  logic signed [Q_W-1:0]   corner[4];
  logic signed [TX_W-1:0]  d1, d2;
  logic        [WT_W-1:0]  w1, w2;
  logic signed [Q_W-1:0]   b_q;
  logic signed [ACC_W-1:0] acc;
  logic signed [H_W-1:0]   h_sum;
  logic        [Q_W-1:0]   h_sat;
  logic        [Q_W-1:0]   res_height;
  logic        res_oor;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      world_x     <= '0;
      world_z     <= '0;
      world_y     <= '0;
      origin_x    <= '0;
      origin_z    <= '0;
      inv_spacing <= Q_W'(ONE_Q16);
    end else if (cfg_valid) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_WORLD_X:     world_x     <= cfg_data;
        REG_WORLD_Z:     world_z     <= cfg_data;
        REG_WORLD_Y:     world_y     <= cfg_data;
        REG_ORIGIN_X:    origin_x    <= cfg_data;
        REG_ORIGIN_Z:    origin_z    <= cfg_data;
        REG_INV_SPACING: inv_spacing <= cfg_data;
        default: ;
      endcase
    end
  end

  // Shared multiplier: signed operand by unsigned 17-bit weight
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_XH: begin
        mul_a = tx;
        mul_b = {1'b0, inv_spacing[Q_W-1:FRAC_W]};
      end
      MUL_XL: begin
        mul_a = tx;
        mul_b = {1'b0, inv_spacing[FRAC_W-1:0]};
      end
      MUL_ZH: begin
        mul_a = tz;
        mul_b = {1'b0, inv_spacing[Q_W-1:FRAC_W]};
      end
      MUL_ZL: begin
        mul_a = tz;
        mul_b = {1'b0, inv_spacing[FRAC_W-1:0]};
      end
      MUL_D1: begin
        mul_a = d1;
        mul_b = w1;
      end
      MUL_D2: begin
        mul_a = d2;
        mul_b = w2;
      end
      default: begin
        mul_a = tx;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * $signed({1'b0, mul_b});
  end

  // floor(t * inv / 2^16) = t*hi + floor(t*lo / 2^16)
  assign g_sum = hold_q + (mul_q >>> FRAC_W);

  assign cx = gx[GX_W-1:FRAC_W];
  assign cz = gz[GX_W-1:FRAC_W];
  assign stat.in_range = !cx[CX_W-1] && (cx <= CX_W'(GRID_SIDE - 2)) &&
                         !cz[CX_W-1] && (cz <= CX_W'(GRID_SIDE - 2));
  assign base_next = ADDR_W'(ADDR_W'(cz[CELL_W-1:0]) * ADDR_W'(GRID_SIDE)) +
                     ADDR_W'(cx[CELL_W-1:0]);

  always_ff @(posedge clk) begin
    mul_q <= mul_p;
    if (cmd.load_in) begin
      tx <= TX_W'(query_x) - TX_W'(world_x) - TX_W'(origin_x);
      tz <= TX_W'(query_z) - TX_W'(world_z) - TX_W'(origin_z);
    end
    if (cmd.hold_en) begin
      hold_q <= mul_q;
    end
    if (cmd.gx_en) begin
      gx <= g_sum;
    end
    if (cmd.gz_en) begin
      gz <= g_sum;
    end
    if (cmd.chk_en) begin
      base  <= base_next;
      fx    <= gx[FRAC_W-1:0];
      fz    <= gz[FRAC_W-1:0];
      lower <= (({1'b0, gx[FRAC_W-1:0]} + {1'b0, gz[FRAC_W-1:0]}) <= WT_W'(ONE_Q16));
    end
  end

  // Height memory, one port
  always_comb begin
    unique case (cmd.corner)
      CORNER_LB: rd_addr = base;
      CORNER_RB: rd_addr = base + ADDR_W'(1);
      CORNER_LT: rd_addr = base + ADDR_W'(GRID_SIDE);
      CORNER_RT: rd_addr = base + ADDR_W'(GRID_SIDE + 1);
      default:   rd_addr = base;
    endcase
  end

  assign mem_we   = cmd.wr_mem && (32'(vertex_index) < 32'(GRID_CELLS));
  assign mem_addr = cmd.wr_mem ? ADDR_W'(vertex_index) : rd_addr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= write_height;
    end else if (cmd.rd_en) begin
      mem_q <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_q <= 1'b0;
    end else begin
      cap_q <= cmd.rd_en;
    end
    cap_idx <= cmd.corner;
    if (cap_q) begin
      corner[cap_idx] <= mem_q;
    end
  end

  // Triangle select and interpolation
  always_ff @(posedge clk) begin
    if (cmd.diff_en) begin
      if (lower) begin
        b_q <= corner[CORNER_LB];
        d1  <= TX_W'(corner[CORNER_RB]) - TX_W'(corner[CORNER_LB]);
        d2  <= TX_W'(corner[CORNER_LT]) - TX_W'(corner[CORNER_LB]);
        w1  <= {1'b0, fx};
        w2  <= {1'b0, fz};
      end else begin
        b_q <= corner[CORNER_RT];
        d1  <= TX_W'(corner[CORNER_LT]) - TX_W'(corner[CORNER_RT]);
        d2  <= TX_W'(corner[CORNER_RB]) - TX_W'(corner[CORNER_RT]);
        w1  <= WT_W'(ONE_Q16) - {1'b0, fx};
        w2  <= WT_W'(ONE_Q16) - {1'b0, fz};
      end
    end
    if (cmd.acc_init) begin
      acc <= (ACC_W'(b_q) <<< FRAC_W) + mul_q;
    end else if (cmd.acc_add) begin
      acc <= acc + mul_q;
    end
  end

  // Round toward minus infinity, add world y, saturate
  always_comb begin
    h_sum = H_W'(acc >>> FRAC_W) + H_W'(world_y);
    if ((h_sum[H_W-1:Q_W-1] == '0) || (h_sum[H_W-1:Q_W-1] == '1)) begin
      h_sat = h_sum[Q_W-1:0];
    end else if (h_sum[H_W-1]) begin
      h_sat = {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      h_sat = {1'b0, {(Q_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.res_sel)
      RES_HOLD: ;
      RES_WRITE: begin
        res_height <= '0;
        res_oor    <= 1'b0;
      end
      RES_OOR: begin
        res_height <= '0;
        res_oor    <= 1'b1;
      end
      RES_INTERP: begin
        res_height <= h_sat;
        res_oor    <= 1'b0;
      end
      default: ;
    endcase
  end

  // Output register
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.push) begin
      out_height <= res_height;
      out_oor    <= res_oor;
    end
  end

endmodule
`default_nettype wire

[src/grid_height_query_unit.sv]
// Height lookup on a square grid of signed Q16.16 heights.
//
// Input stream (s_axis_*): one beat per item. tuser selects the item kind:
// a write stores write_height at vertex_index (row*side + column; indexes
// past the grid are dropped), a query returns the height at world (x, z).
// Output stream (m_axis_*): exactly one beat per input beat, in order.
// tdata carries the height, tuser flags a query cell outside the grid
// (height 0 then). Writes return height 0 with the flag clear.
// Configuration (cfg_*): index 0..5 = world_x, world_z, world_y, origin_x,
// origin_z, inv_spacing; other indexes are ignored. Write only while idle.
// Sequence: a write goes straight to the result step; a query first forms
// the grid coordinate and checks the cell, and an in-grid query then reads
// the four corners and interpolates. The item time is set by the four
// corner fetches through the single height memory port and the shared 34x17
// multiplier (four passes for the grid coordinate, two for interpolation).
// One item is in work at a time; a result waiting for tready sits in the
// output register while the next item is taken. A second result holds in
// the final step with s_axis_tready low until the register frees.
// Reset clears control state and the configuration registers (inv_spacing
// to 1.0); the height memory is not cleared and must be written before use.
`default_nettype none
module grid_height_query_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // slave side
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [14:0] vertex_index, [46:15] write_height, [78:47] query_x,
  // [110:79] query_z, [111] zero
  input  wire logic [ghq_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // [0] cmd: 0 write height, 1 query height
  input  wire logic                            s_axis_tuser,
  // master side
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [31:0] height
  output logic [ghq_pkg::Q_W-1:0]              m_axis_tdata,
  // [0] out_of_range
  output logic                                 m_axis_tuser,
  // configuration write channel
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [ghq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ghq_pkg::Q_W-1:0]         cfg_data
);
  import ghq_pkg::*;

  ghq_cmd_t  cmd;
  ghq_stat_t stat;

  // Unpack the input beat, first field in the low bits
  logic        [IDX_W-1:0] vertex_index;
  logic signed [Q_W-1:0]   write_height, query_x, query_z;

  assign vertex_index = s_axis_tdata[IDX_W-1:0];
  assign write_height = s_axis_tdata[IDX_W +: Q_W];
  assign query_x      = s_axis_tdata[IDX_W + Q_W +: Q_W];
  assign query_z      = s_axis_tdata[IDX_W + 2*Q_W +: Q_W];

  // Sequencer: accepts a beat only when idle, steps the datapath
  ghq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_cmd   (s_axis_tuser),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Config registers, height memory, multiplier, output register
  ghq_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg_ready    (cfg_ready),
    .vertex_index (vertex_index),
    .write_height (write_height),
    .query_x      (query_x),
    .query_z      (query_z),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_height   (m_axis_tdata),
    .out_oor      (m_axis_tuser)
  );

endmodule
`default_nettype wire

[test/tb_grid_height_query_unit.sv]
`timescale 1ns / 1ps
module tb_grid_height_query_unit;
  import ghq_pkg::*;

  localparam int    RESET_CYCLES    = 8;
  localparam int    IDLE_SETTLE     = 24;   // longer than an in-grid query
  localparam int    HOLD_OFF_CYCLES = 200;
  localparam int    PHASE_ITEMS     = 170;
  localparam int    CYCLE_LIMIT     = 1000000;
  localparam int    MAX_REPORTS     = 10;
  localparam longint H_MAX          = 64'sd2147483647;
  localparam longint H_MIN          = -64'sd2147483648;

  // Indexes past the register list; the block must drop these writes.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [Q_W-1:0] height;
    logic           out_of_range;
  } height_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // [14:0] vertex_index, [46:15] write_height, [78:47] query_x,
  // [110:79] query_z, [111] zero
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  // [0] cmd
  logic                 s_axis_tuser = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // [31:0] height
  logic [Q_W-1:0]       m_axis_tdata;
  // [0] out_of_range
  logic                 m_axis_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [Q_W-1:0]       cfg_data = '0;

  grid_height_query_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Shadow of the block: height grid, which entries hold a written value,
  // and the configuration registers as last written.
  // ---------------------------------------------------------------------
  logic [Q_W-1:0]     height_map   [GRID_CELLS];
  bit                 height_known [GRID_CELLS];
  logic signed [31:0] world_x_q   = '0;
  logic signed [31:0] world_z_q   = '0;
  logic signed [31:0] world_y_q   = '0;
  logic signed [31:0] origin_x_q  = '0;
  logic signed [31:0] origin_z_q  = '0;
  logic [31:0]        inv_spacing_q = ONE_Q16;

  height_result_t pending_heights[$];

  int  items_sent     = 0;
  int  queries_sent   = 0;
  int  outside_sent   = 0;
  int  results_seen   = 0;
  int  mismatch_count = 0;
  int  cycle_count    = 0;
  int  sink_hold_cycles = 0;
  bit  send_no_idle   = 1'b0;
  bit  sink_no_idle   = 1'b0;

  // Grid coordinate in Q.16: (pos - world - origin) * inv_spacing, floored.
  function automatic longint grid_coord(input logic [31:0] pos,
                                        input logic signed [31:0] world_ofs,
                                        input logic signed [31:0] page_ofs);
    logic signed [95:0] scaled;
    longint             local_pos;
    local_pos = longint'($signed(pos)) - longint'(world_ofs) - longint'(page_ofs);
    scaled    = local_pos * $signed({1'b0, inv_spacing_q});
    return longint'(scaled >>> FRAC_W);
  endfunction

  function automatic void locate_cell(input logic [31:0] qx, qz,
                                      output longint cx, cz, fx, fz);
    longint gx, gz;
    gx = grid_coord(qx, world_x_q, origin_x_q);
    gz = grid_coord(qz, world_z_q, origin_z_q);
    cx = gx >>> FRAC_W;
    cz = gz >>> FRAC_W;
    fx = gx - (cx <<< FRAC_W);
    fz = gz - (cz <<< FRAC_W);
  endfunction

  // All four corners exist only up to GRID_SIDE-2; the far edge is outside.
  function automatic bit cell_inside(input longint cx, cz);
    return cx >= 0 && cz >= 0 && cx <= GRID_SIDE - 2 && cz <= GRID_SIDE - 2;
  endfunction

  function automatic height_result_t predict_query(input logic [31:0] qx, qz);
    height_result_t res;
    longint         cx, cz, fx, fz, lb, rb, lt, rt, acc, h;
    int             base;
    res.height       = '0;
    res.out_of_range = 1'b1;
    locate_cell(qx, qz, cx, cz, fx, fz);
    if (!cell_inside(cx, cz)) return res;
    base = int'(cx + cz * GRID_SIDE);
    lb = longint'($signed(height_map[base]));
    rb = longint'($signed(height_map[base + 1]));
    lt = longint'($signed(height_map[base + GRID_SIDE]));
    rt = longint'($signed(height_map[base + GRID_SIDE + 1]));
    // Lower-left triangle includes the diagonal itself.
    if (fx + fz <= ONE_Q16) begin
      acc = lb * ONE_Q16 + fx * (rb - lb) + fz * (lt - lb);
    end else begin
      acc = rt * ONE_Q16 + (ONE_Q16 - fx) * (lt - rt) + (ONE_Q16 - fz) * (rb - rt);
    end
    h = (acc >>> FRAC_W) + longint'(world_y_q);
    if (h > H_MAX) h = H_MAX;
    if (h < H_MIN) h = H_MIN;
    res.height       = h[Q_W-1:0];
    res.out_of_range = 1'b0;
    return res;
  endfunction

  function automatic logic [31:0] draw_word();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Cell row or column for aimed queries: mostly a small corner window and
  // the far edge, now and then one step outside on either side.
  function automatic int pick_cell();
    case ($urandom_range(0, 9))
      0: return -1;
      1: return GRID_SIDE - 1;
      2, 3: return $urandom_range(GRID_SIDE - 4, GRID_SIDE - 2);
      4: return $urandom_range(0, GRID_SIDE - 2);
      default: return $urandom_range(0, 5);
    endcase
  endfunction

  function automatic int pick_fraction();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return ONE_Q16 - 1;
      default: return $urandom_range(0, ONE_Q16 - 1);
    endcase
  endfunction

  task automatic note_mismatch(input string what, input height_result_t want,
                               input logic [Q_W-1:0] got_height, input logic got_oor);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t: %s: expected height %h oor %b, got height %h oor %b",
               $time, what, want.height, want.out_of_range, got_height, got_oor);
    end
  endtask

  // ---------------------------------------------------------------------
  // Input side: one beat per call. Drive at the falling edge, take the
  // beat at the rising edge, and predict its result right there so the
  // shadow grid follows the block's order exactly.
  // ---------------------------------------------------------------------
  task automatic send_item(input item_cmd_e cmd, input logic [IDX_W-1:0] idx,
                           input logic [31:0] wr_height, qx, qz);
    int             gap;
    height_result_t want;
    gap = send_no_idle ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {1'b0, qz, qx, wr_height, idx};
    do @(posedge clk); while (!s_axis_tready);
    if (cmd == CMD_WRITE) begin
      // Indexes past the grid are dropped by the block.
      if (idx < GRID_CELLS) begin
        height_map[idx]   = wr_height;
        height_known[idx] = 1'b1;
      end
      want.height       = '0;
      want.out_of_range = 1'b0;
    end else begin
      want = predict_query(qx, qz);
      queries_sent++;
      if (want.out_of_range) outside_sent++;
    end
    pending_heights.push_back(want);
    items_sent++;
  endtask

  // Query at (qx, qz); fill any corner that was never written first so the
  // block never reads an unset grid entry.
  task automatic send_query(input logic [31:0] qx, qz);
    longint cx, cz, fx, fz;
    int     base, ofs;
    locate_cell(qx, qz, cx, cz, fx, fz);
    if (cell_inside(cx, cz)) begin
      base = int'(cx + cz * GRID_SIDE);
      for (int k = 0; k < 4; k++) begin
        ofs = (k & 1) + (k >> 1) * GRID_SIDE;
        if (!height_known[base + ofs]) begin
          send_item(CMD_WRITE, IDX_W'(base + ofs), draw_word(), $urandom(), $urandom());
        end
      end
    end
    send_item(CMD_QUERY, IDX_W'($urandom()), $urandom(), qx, qz);
  endtask

  task automatic send_random_item();
    int               roll, cx, cz, fx, fz;
    longint           gx, gz, lx, lz, wide;
    logic [IDX_W-1:0] idx;
    logic [31:0]      qx, qz;
    roll = $urandom_range(0, 99);
    if (roll < 20) begin
      // Mostly valid vertexes; some full-width indexes that fall past the grid.
      idx = (roll < 5) ? IDX_W'($urandom()) : IDX_W'($urandom_range(0, GRID_CELLS - 1));
      send_item(CMD_WRITE, idx, draw_word(), $urandom(), $urandom());
    end else if (roll < 32) begin
      send_query(draw_word(), draw_word());
    end else begin
      // Aim at a cell and fraction, then map back to world space through
      // the current offsets and spacing.
      cx = pick_cell();
      cz = pick_cell();
      fx = pick_fraction();
      fz = pick_fraction();
      if ($urandom_range(0, 5) == 0 && fx != 0) fz = ONE_Q16 - fx;  // on the diagonal
      gx = longint'(cx) * ONE_Q16 + fx;
      gz = longint'(cz) * ONE_Q16 + fz;
      if (inv_spacing_q == 0) begin
        lx = gx;
        lz = gz;
      end else begin
        lx = (gx * ONE_Q16) / longint'({32'b0, inv_spacing_q});
        lz = (gz * ONE_Q16) / longint'({32'b0, inv_spacing_q});
      end
      wide = lx + longint'(world_x_q) + longint'(origin_x_q);
      qx   = wide[31:0];
      wide = lz + longint'(world_z_q) + longint'(origin_z_q);
      qz   = wide[31:0];
      send_query(qx, qz);
    end
  endtask

  // Drop valid and let every pending result out, then give the block time
  // to settle before the next register write.
  task automatic wait_idle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_heights.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] index, input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      REG_WORLD_X:     world_x_q     = value;
      REG_WORLD_Z:     world_z_q     = value;
      REG_WORLD_Y:     world_y_q     = value;
      REG_ORIGIN_X:    origin_x_q    = value;
      REG_ORIGIN_Z:    origin_z_q    = value;
      REG_INV_SPACING: inv_spacing_q = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_config_phase(input logic [31:0] wx, wz, wy, ox, oz, inv,
                                  input int n_items);
    int phase_end;
    wait_idle();
    write_register(REG_WORLD_X, wx);
    write_register(REG_WORLD_Z, wz);
    write_register(REG_WORLD_Y, wy);
    write_register(REG_ORIGIN_X, ox);
    write_register(REG_ORIGIN_Z, oz);
    write_register(REG_INV_SPACING, inv);
    phase_end = items_sent + n_items;
    while (items_sent < phase_end) send_random_item();
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset configuration: unit spacing, no offsets, so query = grid coord.
  task automatic test_directed_grid();
    // Corners of the first and the last cell, extreme heights.
    send_item(CMD_WRITE, IDX_W'(0), 32'h7FFF_FFFF, 0, 0);
    send_item(CMD_WRITE, IDX_W'(1), 32'h8000_0000, 0, 0);
    send_item(CMD_WRITE, IDX_W'(GRID_SIDE), 32'h0001_0000, 0, 0);
    send_item(CMD_WRITE, IDX_W'(GRID_SIDE + 1), 32'hFFFF_0000, 0, 0);
    send_item(CMD_WRITE, IDX_W'(GRID_CELLS - GRID_SIDE - 2), $urandom(), 0, 0);
    send_item(CMD_WRITE, IDX_W'(GRID_CELLS - GRID_SIDE - 1), 32'h0000_0000, 0, 0);
    send_item(CMD_WRITE, IDX_W'(GRID_CELLS - 2), 32'h8000_0000, 0, 0);
    send_item(CMD_WRITE, IDX_W'(GRID_CELLS - 1), 32'h7FFF_FFFF, 0, 0);
    // Writes past the grid: dropped, must not disturb anything.
    send_item(CMD_WRITE, IDX_W'(GRID_CELLS), 32'h1234_5678, 0, 0);
    send_item(CMD_WRITE, {IDX_W{1'b1}}, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Exact vertex, diagonal, just above the diagonal, near the far corner.
    send_query(32'h0000_0000, 32'h0000_0000);
    send_query(32'h0000_8000, 32'h0000_8000);
    send_query(32'h0000_8001, 32'h0000_8000);
    send_query(32'h0000_FFFF, 32'h0000_FFFF);
    send_query(32'h0000_0000, 32'h0000_FFFF);
    // Last cell, both triangles.
    send_query({16'(GRID_SIDE - 2), 16'h0000}, {16'(GRID_SIDE - 2), 16'h0000});
    send_query({16'(GRID_SIDE - 2), 16'hFFFF}, {16'(GRID_SIDE - 2), 16'hFFFF});
    // Last row of cells in z only.
    send_query(32'h0000_0000, {16'(GRID_SIDE - 1), 16'h0000} - 32'd1);
    // Outside: far edge, one step below zero, full-scale positions.
    send_query({16'(GRID_SIDE - 1), 16'h0000}, 32'h0000_0000);
    send_query(32'h0000_0000, 32'hFFFF_FFFF);
    send_query(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_query(32'h8000_0000, 32'h8000_0000);
  endtask

  // World y offset pushes the sum past either end of the 32-bit range.
  task automatic test_saturation();
    wait_idle();
    write_register(REG_WORLD_Y, 32'h7FFF_FFFF);
    send_query(32'h0000_0000, 32'h0000_0000);
    wait_idle();
    write_register(REG_WORLD_Y, 32'h8000_0000);
    send_query(32'h0001_0000, 32'h0000_0000);
  endtask

  task automatic test_config_sweep();
    // Reset values written explicitly, plus the two spare indexes.
    wait_idle();
    write_register(REG_SPARE_LO, $urandom());
    write_register(REG_SPARE_HI, $urandom());
    run_config_phase(0, 0, 0, 0, 0, ONE_Q16, PHASE_ITEMS);
    // Fine spacing with small offsets, no idling on either side.
    send_no_idle = 1'b1;
    sink_no_idle = 1'b1;
    run_config_phase($urandom_range(0, 32'h0008_0000), $urandom_range(0, 32'h0008_0000),
                     $urandom(), -$urandom_range(0, 32'h0004_0000),
                     $urandom_range(0, 32'h0004_0000), 32'h0002_0000, PHASE_ITEMS);
    send_no_idle = 1'b0;
    sink_no_idle = 1'b0;
    run_config_phase($urandom(), $urandom(), 32'h0000_0000, $urandom(), $urandom(),
                     32'h0000_4000, PHASE_ITEMS);
    // Full-scale offsets and spacing.
    run_config_phase(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h7FFF_FFFF, 32'hFFFF_FFFF, PHASE_ITEMS);
    // Zero inverse spacing: every position lands on vertex (0,0).
    run_config_phase($urandom(), $urandom(), 32'h8000_0000, $urandom(), $urandom(),
                     32'h0000_0000, PHASE_ITEMS);
    run_config_phase($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                     $urandom_range(32'h0000_4000, 32'h0004_0000), PHASE_ITEMS);
  endtask

  // Receiver stops for a long stretch while the sender keeps offering
  // beats back to back; the block has to fill and hold its input off.
  task automatic test_backpressure();
    wait_idle();
    write_register(REG_INV_SPACING, ONE_Q16);
    sink_hold_cycles = HOLD_OFF_CYCLES;
    send_no_idle     = 1'b1;
    repeat (40) send_random_item();
    send_no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Output side: random ready gaps, plus the long hold-off when requested.
  // ---------------------------------------------------------------------
  initial begin : result_sink
    int stall_n;
    while (rst) @(negedge clk);
    forever begin
      if (sink_hold_cycles != 0) begin
        m_axis_tready <= 1'b0;
        repeat (sink_hold_cycles) @(negedge clk);
        sink_hold_cycles = 0;
      end
      stall_n = sink_no_idle ? 0 : $urandom_range(0, 3);
      if (stall_n != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall_n) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      // Hold ready until a beat goes through.
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
      @(negedge clk);
    end
  end

  // Compare each result beat with the oldest prediction.
  always @(posedge clk) begin : check_results
    height_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_heights.size() == 0) begin
        want.height       = '0;
        want.out_of_range = 1'b0;
        note_mismatch("result beat with nothing pending", want, m_axis_tdata, m_axis_tuser);
      end else begin
        want = pending_heights.pop_front();
        if (m_axis_tdata != want.height || m_axis_tuser != want.out_of_range) begin
          note_mismatch(m_axis_tdata != want.height ? "height mismatch" : "out_of_range mismatch",
                        want, m_axis_tdata, m_axis_tuser);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, pending_heights.size());
      $display("grid_height_query_unit regression: fail");
      $finish;
    end
  end

  initial begin : regression
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    test_directed_grid();
    test_saturation();
    test_config_sweep();
    test_backpressure();
    // Drain, then allow the longest item latency for stray beats.
    wait_idle();
    repeat (IDLE_SETTLE) @(posedge clk);
    $display("run covered %0d items: %0d queries (%0d outside the grid), %0d result beats",
             items_sent, queries_sent, outside_sent, results_seen);
    $display("six register settings, saturation both ways, a %0d-cycle hold-off; %0d mismatches",
             HOLD_OFF_CYCLES, mismatch_count);
    if (mismatch_count == 0) begin
      $display("grid_height_query_unit regression: pass");
    end else begin
      $display("grid_height_query_unit regression: fail");
    end
    $finish;
  end

endmodule
